@@ rtl/lrm_pkg.sv @@
// ----------------------------------------------------------------------------
// lrm_pkg
// Shared constants and types of the luminance ranked 3x3 median filter.
// ----------------------------------------------------------------------------
`default_nettype none

package lrm_pkg;

    // Default sizing of the core
    localparam int DefaultMaxWidth      = 1024;
    localparam int DefaultComponentBits = 16;

    // Fixed field widths of the result word and of the frame registers
    localparam int OutXBits     = 10;
    localparam int OutYBits     = 12;
    localparam int HeightBits   = 13;
    localparam int CfgDataBits  = 13;
    localparam int WidthFieldBits = 11;

    // Frame height limit and reset values
    localparam int HeightLimit  = 4096;
    localparam int ResetWidth   = 1024;
    localparam int ResetHeight  = 1024;

    // Q16 BT.601 luma weights (sum to 65536)
    localparam int WeightBits = 16;
    localparam logic [WeightBits-1:0] WEIGHT_R = 16'd19595;
    localparam logic [WeightBits-1:0] WEIGHT_G = 16'd38470;
    localparam logic [WeightBits-1:0] WEIGHT_B = 16'd7471;

    // Window geometry
    localparam int WinCells  = 9;
    localparam int WinCenter = 4;
    localparam int MedianRank = 4;

    // Operation codes carried in tuser
    typedef enum logic {
        OP_PUSH  = 1'b0,
        OP_DRAIN = 1'b1
    } op_t;

    // Configuration register indexes
    typedef enum logic {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } cfg_index_t;

    // Position and end flag that travel with a window down the ranking pipe
    typedef struct packed {
        logic [OutXBits-1:0] x;
        logic [OutYBits-1:0] y;
        logic                last;
    } pos_meta_t;

endpackage

`default_nettype wire

@@ rtl/lrm_rank.sv @@
// ----------------------------------------------------------------------------
// lrm_rank
// Four-stage ranking pipe: weight, sum luma, pairwise order, pick median.
// ----------------------------------------------------------------------------
`default_nettype none

module lrm_rank #(
    parameter int COMPONENT_BITS = lrm_pkg::DefaultComponentBits
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        advance,
    input  wire logic                        in_valid,
    input  wire logic [3*COMPONENT_BITS-1:0] in_pixels [lrm_pkg::WinCells],
    input  wire lrm_pkg::pos_meta_t          in_meta,
    output logic                             out_valid,
    output logic [3*COMPONENT_BITS-1:0]      out_pixel,
    output lrm_pkg::pos_meta_t               out_meta
);
    import lrm_pkg::*;

    localparam int CB     = COMPONENT_BITS;
    localparam int PIX_W  = 3 * CB;
    localparam int PROD_W = CB + WeightBits;
    localparam int LUM_W  = PROD_W + 2;

    // stage 1: products
    logic              s1_valid_reg;
    logic [PROD_W-1:0] s1_prod_reg [WinCells][3];
    logic [PIX_W-1:0]  s1_pix_reg  [WinCells];
    pos_meta_t         s1_meta_reg;
    // stage 2: luma
    logic              s2_valid_reg;
    logic [LUM_W-1:0]  s2_lum_reg [WinCells];
    logic [PIX_W-1:0]  s2_pix_reg [WinCells];
    pos_meta_t         s2_meta_reg;
    // stage 3: precedence matrix
    logic              s3_valid_reg;
    logic [WinCells-1:0] s3_prec_reg [WinCells];
    logic [PIX_W-1:0]  s3_pix_reg [WinCells];
    pos_meta_t         s3_meta_reg;
    // stage 4: result
    logic              s4_valid_reg;
    logic [PIX_W-1:0]  s4_pix_reg;
    pos_meta_t         s4_meta_reg;

    logic [PIX_W-1:0]  median_next;

    always_comb begin
        median_next = s3_pix_reg[WinCenter];
        for (int n = 0; n < WinCells; n++) begin
            if ($countones(s3_prec_reg[n]) == MedianRank) begin
                median_next = s3_pix_reg[n];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int n = 0; n < WinCells; n++) begin
                s1_prod_reg[n][0] <= PROD_W'(in_pixels[n][CB-1:0]) * PROD_W'(WEIGHT_R);
                s1_prod_reg[n][1] <= PROD_W'(in_pixels[n][2*CB-1:CB]) * PROD_W'(WEIGHT_G);
                s1_prod_reg[n][2] <= PROD_W'(in_pixels[n][3*CB-1:2*CB]) * PROD_W'(WEIGHT_B);
                s1_pix_reg[n]     <= in_pixels[n];
                s2_lum_reg[n]     <= LUM_W'(s1_prod_reg[n][0]) + LUM_W'(s1_prod_reg[n][1])
                                   + LUM_W'(s1_prod_reg[n][2]);
                s2_pix_reg[n]     <= s1_pix_reg[n];
                for (int j = 0; j < WinCells; j++) begin
                    s3_prec_reg[n][j] <= (s2_lum_reg[j] < s2_lum_reg[n]) ||
                                         ((s2_lum_reg[j] == s2_lum_reg[n]) && (j < n));
                end
                s3_pix_reg[n] <= s2_pix_reg[n];
            end
            s1_meta_reg <= in_meta;
            s2_meta_reg <= s1_meta_reg;
            s3_meta_reg <= s2_meta_reg;
            s4_meta_reg <= s3_meta_reg;
            s4_pix_reg  <= median_next;
        end
    end

    assign out_valid = s4_valid_reg;
    assign out_pixel = s4_pix_reg;
    assign out_meta  = s4_meta_reg;

endmodule

`default_nettype wire

@@ rtl/luma_ranked_median_3x3_core.sv @@
// ----------------------------------------------------------------------------
// luma_ranked_median_3x3_core
// 3x3 vector median filter over an RGB raster stream, ranked by BT.601 luma.
// ----------------------------------------------------------------------------
// Push pixels in raster order (tuser = 0) and receive, for every frame
// position, the whole RGB neighbor whose Q16 luma is the median of its 3x3
// window; a luma tie ranks the lower index first; neighbors outside the frame
// take the center pixel. Results trail the input by frame_width+1 words;
// after the last pixel send frame_width+1 drain words (tuser = 1) to flush
// the tail. A push after a complete frame starts the next frame and drops
// any undrained outputs. One word is taken every clock; the only stall is
// back-pressure from the result side. An accepted word reaches its result
// word through registered steps: window update, multiply, luma sum,
// pairwise compare, median pick. Both line stores share one single-write
// memory with two registered read ports: one prefetches the next column,
// the other holds column 0 for the start of a new frame; a write in the
// cycle before a read of the same entry is forwarded. Write registers only
// while idle; each write restarts the frame. Line stores have no reset.
// ----------------------------------------------------------------------------
`default_nettype none

module luma_ranked_median_3x3_core #(
    parameter int MAX_WIDTH      = lrm_pkg::DefaultMaxWidth,
    parameter int COMPONENT_BITS = lrm_pkg::DefaultComponentBits
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    // input word: tdata = red, green, blue from bit 0 up; tuser = operation
    input  wire logic                                      s_tvalid,
    output logic                                           s_tready,
    input  wire logic [((3*COMPONENT_BITS+7)/8)*8-1:0]     s_tdata,
    input  wire logic                                      s_tuser,
    // result word: tdata = out_red, out_green, out_blue, out_x, out_y
    // from bit 0 up; tlast = frame_end
    output logic                                           m_tvalid,
    input  wire logic                                      m_tready,
    output logic [((3*COMPONENT_BITS+22+7)/8)*8-1:0]       m_tdata,
    output logic                                           m_tlast,
    // register writes: index 0 frame_width, 1 frame_height
    input  wire logic                                      cfg_valid,
    output logic                                           cfg_ready,
    input  wire lrm_pkg::cfg_index_t                       cfg_index,
    input  wire logic [lrm_pkg::CfgDataBits-1:0]           cfg_data
);
    import lrm_pkg::*;

    localparam int CB         = COMPONENT_BITS;
    localparam int PIX_W      = 3 * CB;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int FW_W       = $clog2(MAX_WIDTH + 1);
    localparam int LAG_W      = $clog2(MAX_WIDTH + 2);
    localparam int OUT_DATA_W = ((PIX_W + OutXBits + OutYBits + 7) / 8) * 8;

    // frame registers
    logic [FW_W-1:0]       width_reg, width_next;
    logic [HeightBits-1:0] height_reg, height_next;
    logic [COL_W-1:0]      in_col_reg, in_col_next;
    logic [OutYBits-1:0]   in_row_reg, in_row_next;
    logic [COL_W-1:0]      out_col_reg, out_col_next;
    logic [OutYBits-1:0]   out_row_reg, out_row_next;
    logic [LAG_W-1:0]      lag_reg, lag_next;
    logic                  received_reg, received_next;
    logic [PIX_W-1:0]      window_reg [WinCells];
    logic [PIX_W-1:0]      window_next [WinCells];

    // line store memory: entry = {upper, middle}
    logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] rd_data_reg, rd0_data_reg, fwd_data_reg;
    logic               hit_reg, hit0_reg;
    logic               wr_en;
    logic [COL_W-1:0]   wr_addr;
    logic [2*PIX_W-1:0] wr_data, line_q, line0_q, line_sel;

    // stage 0: substituted window toward the ranking pipe
    logic              st0_valid_reg;
    logic [PIX_W-1:0]  st0_pix_reg [WinCells];
    pos_meta_t         st0_meta_reg;
    logic [PIX_W-1:0]  sub_pix [WinCells];
    pos_meta_t         meta_next;

    // handshake and per-word control
    logic advance, accept, is_push, slot, restart_push, emit, last, cfg_write;
    logic [COL_W-1:0]      c0, oc0;
    logic [OutYBits-1:0]   r0, or0;
    logic [LAG_W-1:0]      lag0;
    logic [FW_W-1:0]       col_inc, ocol_inc;
    logic [HeightBits-1:0] row_inc, orow_inc;
    logic                  col_wrap;
    logic [PIX_W-1:0]      pix_in, col_top, col_mid, col_bot;
    logic [FW_W-1:0]       width_wr;
    logic [HeightBits-1:0] height_wr;

    logic              rk_valid;
    logic [PIX_W-1:0]  rk_pixel;
    pos_meta_t         rk_meta;

    // the whole pipe moves when the result register is free or being taken
    assign advance   = !m_tvalid || m_tready;
    assign s_tready  = advance;
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign is_push   = (s_tuser == OP_PUSH);
    assign cfg_write = cfg_valid && cfg_ready;

    assign pix_in  = s_tdata[PIX_W-1:0];

    // forward a write from last cycle over the stale read
    assign line_q   = hit_reg  ? fwd_data_reg : rd_data_reg;
    assign line0_q  = hit0_reg ? fwd_data_reg : rd0_data_reg;
    assign line_sel = restart_push ? line0_q : line_q;
    assign col_top  = line_sel[2*PIX_W-1:PIX_W];
    assign col_mid  = line_sel[PIX_W-1:0];
    assign col_bot  = is_push ? pix_in : '0;

    assign wr_en   = accept && is_push;
    assign wr_addr = c0;
    assign wr_data = {col_mid, pix_in};

    // clamp register writes to the legal range
    always_comb begin
        width_wr = FW_W'(MAX_WIDTH);
        if (cfg_data[WidthFieldBits-1:0] == '0) begin
            width_wr = FW_W'(1);
        end else if (32'(cfg_data[WidthFieldBits-1:0]) <= 32'(MAX_WIDTH)) begin
            width_wr = FW_W'(cfg_data[WidthFieldBits-1:0]);
        end
        height_wr = HeightBits'(HeightLimit);
        if (cfg_data == '0) begin
            height_wr = HeightBits'(1);
        end else if (32'(cfg_data) <= 32'(HeightLimit)) begin
            height_wr = cfg_data;
        end
    end

    always_comb begin
        slot         = accept && (is_push || received_reg);
        restart_push = accept && is_push && received_reg;

        // a push after a complete frame restarts the position state first
        c0            = restart_push ? '0 : in_col_reg;
        r0            = restart_push ? '0 : in_row_reg;
        oc0           = restart_push ? '0 : out_col_reg;
        or0           = restart_push ? '0 : out_row_reg;
        lag0          = restart_push ? '0 : lag_reg;
        received_next = restart_push ? 1'b0 : received_reg;

        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        lag_next     = lag_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        emit         = 1'b0;

        col_inc  = FW_W'(c0) + FW_W'(1);
        col_wrap = (col_inc >= width_reg);
        row_inc  = HeightBits'(r0) + HeightBits'(1);
        ocol_inc = FW_W'(oc0) + FW_W'(1);
        orow_inc = HeightBits'(or0) + HeightBits'(1);
        last     = (FW_W'(oc0) == width_reg - FW_W'(1)) &&
                   (HeightBits'(or0) == height_reg - HeightBits'(1));

        for (int r = 0; r < 3; r++) begin
            window_next[r*3+0] = window_reg[r*3+1];
            window_next[r*3+1] = window_reg[r*3+2];
        end
        window_next[2] = col_top;
        window_next[5] = col_mid;
        window_next[8] = col_bot;

        if (slot) begin
            // advance the input position
            in_col_next = col_wrap ? '0 : col_inc[COL_W-1:0];
            in_row_next = r0;
            if (is_push && col_wrap) begin
                if (row_inc >= height_reg) begin
                    in_row_next   = '0;
                    received_next = 1'b1;
                end else begin
                    in_row_next = row_inc[OutYBits-1:0];
                end
            end
            out_col_next = oc0;
            out_row_next = or0;
            // hold back the first width+1 slots, then emit
            if (lag0 < LAG_W'(width_reg) + LAG_W'(1)) begin
                lag_next = lag0 + LAG_W'(1);
            end else begin
                emit     = 1'b1;
                lag_next = lag0;
                if (last) begin
                    in_col_next   = '0;
                    in_row_next   = '0;
                    out_col_next  = '0;
                    out_row_next  = '0;
                    lag_next      = '0;
                    received_next = 1'b0;
                end else if (ocol_inc >= width_reg) begin
                    out_col_next = '0;
                    out_row_next = orow_inc[OutYBits-1:0];
                end else begin
                    out_col_next = ocol_inc[COL_W-1:0];
                end
            end
        end

        if (cfg_write) begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  width_next  = width_wr;
                CFG_FRAME_HEIGHT: height_next = height_wr;
                default:          width_next  = width_reg;
            endcase
            in_col_next   = '0;
            in_row_next   = '0;
            out_col_next  = '0;
            out_row_next  = '0;
            lag_next      = '0;
            received_next = 1'b0;
        end
    end

    // replace neighbors outside the frame by the center
    always_comb begin
        for (int n = 0; n < WinCells; n++) begin
            if (((n / 3 == 0) && (or0 == '0)) ||
                ((n / 3 == 2) && (HeightBits'(or0) == height_reg - HeightBits'(1))) ||
                ((n % 3 == 0) && (oc0 == '0)) ||
                ((n % 3 == 2) && (FW_W'(oc0) == width_reg - FW_W'(1)))) begin
                sub_pix[n] = window_next[WinCenter];
            end else begin
                sub_pix[n] = window_next[n];
            end
        end
        meta_next.x    = OutXBits'(oc0);
        meta_next.y    = or0;
        meta_next.last = last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg     <= FW_W'(ResetWidth > MAX_WIDTH ? MAX_WIDTH : ResetWidth);
            height_reg    <= HeightBits'(ResetHeight);
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            lag_reg       <= '0;
            received_reg  <= 1'b0;
            hit_reg       <= 1'b0;
            hit0_reg      <= 1'b0;
            st0_valid_reg <= 1'b0;
            for (int n = 0; n < WinCells; n++) begin
                window_reg[n] <= '0;
            end
        end else begin
            width_reg    <= width_next;
            height_reg   <= height_next;
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            lag_reg      <= lag_next;
            received_reg <= received_next;
            hit_reg      <= wr_en && (wr_addr == in_col_next);
            hit0_reg     <= wr_en && (wr_addr == '0);
            if (advance) begin
                st0_valid_reg <= emit;
            end
            if (slot) begin
                window_reg <= window_next;
            end
        end
    end

    // line store: one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_mem[wr_addr] <= wr_data;
        end
        rd_data_reg  <= line_mem[in_col_next];
        rd0_data_reg <= line_mem[0];
        fwd_data_reg <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            st0_pix_reg  <= sub_pix;
            st0_meta_reg <= meta_next;
        end
    end

    lrm_rank #(
        .COMPONENT_BITS(COMPONENT_BITS)
    ) u_rank (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .in_valid (st0_valid_reg),
        .in_pixels(st0_pix_reg),
        .in_meta  (st0_meta_reg),
        .out_valid(rk_valid),
        .out_pixel(rk_pixel),
        .out_meta (rk_meta)
    );

    assign m_tvalid = rk_valid;
    assign m_tdata  = OUT_DATA_W'({rk_meta.y, rk_meta.x, rk_pixel});
    assign m_tlast  = rk_meta.last;

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the luminance ranked 3x3 median core.
// ----------------------------------------------------------------------------
// A directed table runs first. It covers register clamping, one-pixel frames,
// drains that are ignored, ties in luma and a 3x3 frame. Random small frames
// follow. Every result word is checked against a software copy of the filter
// that runs beside the core. Both sides of the stream idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module testbench;
    import lrm_pkg::*;

    localparam int MaxCols    = 1024;
    localparam int RunLimit   = 600000;
    localparam int SettleWait = 12;

    typedef enum {ROW_CFG, ROW_PRED, ROW_NONE, ROW_KNOWN} row_kind_t;

    typedef struct {
        row_kind_t kind;
        op_t       op;
        bit [15:0] r, g, b;
        bit [15:0] er, eg, eb;
    } stim_row_t;

    typedef struct {
        bit [15:0] r, g, b;
        bit [9:0]  x;
        bit [11:0] y;
        bit        last;
    } median_word_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    wire logic   s_tready;
    logic [47:0] s_tdata = '0;
    logic        s_tuser = 0;
    wire logic   m_tvalid;
    logic        m_tready = 0;
    wire logic [71:0] m_tdata;
    wire logic   m_tlast;
    logic        cfg_valid = 0;
    wire logic   cfg_ready;
    cfg_index_t  cfg_index = CFG_FRAME_WIDTH;
    logic [12:0] cfg_data = '0;

    luma_ranked_median_3x3_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        #10 aclk = 1;
        #10 aclk = 0;
    end

    // ------------------------------------------------------------------
    // Filter copy: line stores, window, positions and the output lag.
    // ------------------------------------------------------------------
    bit [47:0]   upper_line[MaxCols];
    bit [47:0]   middle_line[MaxCols];
    bit [47:0]   win[9];
    int unsigned fw, fh, in_col, in_row, out_col, out_row, lag;
    bit          frame_done;

    median_word_t median_q[$];
    int errors, words_checked, frames_run, pushes_done;
    int burst_left;
    int cycles;

    function automatic longint unsigned luma_of(bit [47:0] p);
        return 64'(WEIGHT_R) * p[15:0] + 64'(WEIGHT_G) * p[31:16] + 64'(WEIGHT_B) * p[47:32];
    endfunction

    function automatic void restart_frame();
        in_col = 0; in_row = 0; out_col = 0; out_row = 0; lag = 0; frame_done = 0;
    endfunction

    function automatic void filter_reset();
        foreach (upper_line[i]) begin
            upper_line[i] = '0;
            middle_line[i] = '0;
        end
        foreach (win[i]) win[i] = '0;
        fw = ResetWidth;
        fh = ResetHeight;
        restart_frame();
    endfunction

    function automatic void filter_config(cfg_index_t idx, bit [12:0] val);
        int unsigned v;
        if (idx == CFG_FRAME_WIDTH) begin
            v = val[10:0];
            if (v == 0) v = 1;
            if (v > MaxCols) v = MaxCols;
            fw = v;
        end else begin
            v = val;
            if (v == 0) v = 1;
            if (v > HeightLimit) v = HeightLimit;
            fh = v;
        end
        restart_frame();
    endfunction

    function automatic void slide_window(bit [47:0] t, bit [47:0] m, bit [47:0] b);
        bit [47:0] col[3];
        col = '{t, m, b};
        for (int r = 0; r < 3; r++) begin
            win[r*3]   = win[r*3+1];
            win[r*3+1] = win[r*3+2];
            win[r*3+2] = col[r];
        end
    endfunction

    // Rank the nine neighbors and emit the median, once the lag is filled.
    function automatic bit pick_median(output median_word_t res);
        bit [47:0]         px[9];
        longint unsigned   lum[9];
        int                sel, rank;
        bit                outside, last;
        if (lag < fw + 1) begin
            lag++;
            return 0;
        end
        sel = WinCenter;
        for (int n = 0; n < 9; n++) begin
            outside = (n / 3 == 0 && out_row == 0) || (n / 3 == 2 && out_row == fh - 1) ||
                      (n % 3 == 0 && out_col == 0) || (n % 3 == 2 && out_col == fw - 1);
            px[n] = outside ? win[WinCenter] : win[n];
            lum[n] = luma_of(px[n]);
        end
        for (int n = 0; n < 9; n++) begin
            rank = 0;
            for (int j = 0; j < 9; j++)
                if (lum[j] < lum[n] || (lum[j] == lum[n] && j < n)) rank++;
            if (rank == MedianRank) sel = n;
        end
        last = (out_col == fw - 1) && (out_row == fh - 1);
        res = '{px[sel][15:0], px[sel][31:16], px[sel][47:32],
                out_col[9:0], out_row[11:0], last};
        if (last) begin
            restart_frame();
        end else begin
            out_col++;
            if (out_col >= fw) begin
                out_col = 0;
                out_row++;
            end
        end
        return 1;
    endfunction

    function automatic bit filter_step(op_t op, bit [47:0] pix, output median_word_t res);
        bit [47:0] t, m;
        int unsigned c;
        if (op == OP_PUSH) begin
            if (frame_done) restart_frame();
            c = (in_col < MaxCols) ? in_col : 0;
            t = upper_line[c];
            m = middle_line[c];
            upper_line[c] = m;
            middle_line[c] = pix;
            slide_window(t, m, pix);
            in_col = c + 1;
            if (in_col >= fw) begin
                in_col = 0;
                in_row++;
                if (in_row >= fh) begin
                    in_row = 0;
                    frame_done = 1;
                end
            end
            return pick_median(res);
        end
        if (!frame_done) return 0;
        c = (in_col < MaxCols) ? in_col : 0;
        slide_window(upper_line[c], middle_line[c], '0);
        in_col = c + 1;
        if (in_col >= fw) in_col = 0;
        return pick_median(res);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus tasks
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("[%0t] mismatch %s: got %0h, want %0h", $realtime, what, got, want);
        errors++;
    endtask

    // Send one word in bursts; queue the median it should produce.
    task automatic send_word(op_t op, bit [47:0] pix, row_kind_t kind, bit [47:0] known);
        median_word_t res;
        bit           has;
        if (burst_left == 0) begin
            if ($urandom_range(0, 2) != 0) begin
                s_tvalid <= 0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_tvalid <= 1;
        s_tuser  <= op;
        s_tdata  <= pix;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        has = filter_step(op, pix, res);
        if (kind == ROW_KNOWN)
            median_q.push_back('{known[15:0], known[31:16], known[47:32], 10'd0, 12'd0, 1'b1});
        else if (kind == ROW_PRED && has)
            median_q.push_back(res);
        if (op == OP_PUSH) pushes_done++;
    endtask

    // Hold the input low until every queued median has come out, then settle.
    task automatic wait_idle();
        s_tvalid <= 0;
        @(posedge aclk);
        while (median_q.size() != 0) @(posedge aclk);
        repeat (SettleWait) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_index_t idx, bit [12:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 0;
        filter_config(idx, val);
        @(posedge aclk);
    endtask

    task automatic set_frame(bit [12:0] w, bit [12:0] h);
        wait_idle();
        write_reg(CFG_FRAME_WIDTH, w);
        write_reg(CFG_FRAME_HEIGHT, h);
        @(posedge aclk);
    endtask

    function automatic bit [47:0] rand_pixel(bit [47:0] prev);
        case ($urandom_range(0, 7))
            0: return prev;                         // equal luma, tie on index
            1: return {3{16'hFFFF}};
            2: return '0;
            3: return {2'($urandom_range(0, 3)), 14'd0, 16'd0, 16'($urandom_range(0, 3))};
            default: return {16'($urandom), 16'($urandom), 16'($urandom)};
        endcase
    endfunction

    // One frame of random content with noise drains and sometimes a cut or longer tail.
    task automatic run_frame(int unsigned w, int unsigned h, bit noisy);
        bit [47:0] p;
        int        tail;
        p = '0;
        for (int i = 0; i < w * h; i++) begin
            if (noisy && $urandom_range(0, 15) == 0)
                send_word(OP_DRAIN, 48'($urandom), ROW_PRED, '0);
            p = rand_pixel(p);
            send_word(OP_PUSH, p, ROW_PRED, '0);
        end
        tail = w + 1;
        if (noisy && $urandom_range(0, 5) == 0) tail = $urandom_range(0, w);
        else if (noisy && $urandom_range(0, 3) == 0) tail += $urandom_range(1, 3);
        repeat (tail) send_word(OP_DRAIN, 48'($urandom), ROW_PRED, '0);
        frames_run++;
    endtask

    // ------------------------------------------------------------------
    // Directed table: one-pixel frames with typed results, then a 3x3 frame.
    // ------------------------------------------------------------------
    stim_row_t dir_rows[25];

    initial begin
        dir_rows = '{
            '{ROW_CFG,   OP_PUSH,  16'd0,     16'd0,     16'd0,    '0, '0, '0},
            '{ROW_NONE,  OP_DRAIN, 16'd0,     16'd0,     16'd0,    '0, '0, '0},
            '{ROW_NONE,  OP_PUSH,  16'hFFFF,  16'hFFFF,  16'hFFFF, '0, '0, '0},
            '{ROW_NONE,  OP_DRAIN, 16'd0,     16'd0,     16'd0,    '0, '0, '0},
            '{ROW_KNOWN, OP_DRAIN, 16'hFFFF,  16'hFFFF,  16'hFFFF,
                                   16'hFFFF,  16'hFFFF,  16'hFFFF},
            '{ROW_NONE,  OP_DRAIN, 16'd0,     16'd0,     16'd0,    '0, '0, '0},
            '{ROW_NONE,  OP_PUSH,  16'h0,     16'h0,     16'h0,    '0, '0, '0},
            '{ROW_NONE,  OP_DRAIN, 16'h0,     16'h0,     16'h0,    '0, '0, '0},
            '{ROW_KNOWN, OP_DRAIN, 16'h0,     16'h0,     16'h0,    '0, '0, '0},
            '{ROW_CFG,   OP_PUSH,  16'd3,     16'd3,     16'd0,    '0, '0, '0},
            '{ROW_PRED,  OP_PUSH,  16'hFFFF,  16'h0,     16'h0,    '0, '0, '0},
            '{ROW_PRED,  OP_PUSH,  16'h0,     16'hFFFF,  16'h0,    '0, '0, '0},
            '{ROW_PRED,  OP_PUSH,  16'h0,     16'h0,     16'hFFFF, '0, '0, '0},
            '{ROW_PRED,  OP_PUSH,  16'h1234,  16'h5678,  16'h9ABC, '0, '0, '0},
            '{ROW_PRED,  OP_DRAIN, 16'h0,     16'h0,     16'h0,    '0, '0, '0},
            '{ROW_PRED,  OP_PUSH,  16'h1234,  16'h5678,  16'h9ABC, '0, '0, '0},
            '{ROW_PRED,  OP_PUSH,  16'h1234,  16'h5678,  16'h9ABC, '0, '0, '0},
            '{ROW_PRED,  OP_PUSH,  16'h8000,  16'h8000,  16'h8000, '0, '0, '0},
            '{ROW_PRED,  OP_PUSH,  16'h0001,  16'h0000,  16'h0000, '0, '0, '0},
            '{ROW_PRED,  OP_PUSH,  16'hFFFF,  16'hFFFF,  16'hFFFF, '0, '0, '0},
            '{ROW_PRED,  OP_DRAIN, 16'h0,     16'h0,     16'h0,    '0, '0, '0},
            '{ROW_PRED,  OP_DRAIN, 16'h0,     16'h0,     16'h0,    '0, '0, '0},
            '{ROW_PRED,  OP_DRAIN, 16'h0,     16'h0,     16'h0,    '0, '0, '0},
            '{ROW_PRED,  OP_DRAIN, 16'h0,     16'h0,     16'h0,    '0, '0, '0},
            '{ROW_PRED,  OP_DRAIN, 16'h0,     16'h0,     16'h0,    '0, '0, '0}
        };

        errors = 0; words_checked = 0; frames_run = 0; pushes_done = 0; burst_left = 0;
        filter_reset();
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Width and height of zero clamp to one, so the first rows are 1x1 frames.
        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG)
                set_frame(13'(dir_rows[i].r), 13'(dir_rows[i].g));
            else
                send_word(dir_rows[i].op, {dir_rows[i].b, dir_rows[i].g, dir_rows[i].r},
                          dir_rows[i].kind, {dir_rows[i].eb, dir_rows[i].eg, dir_rows[i].er});
        end

        pushes_done = 0;
        while (pushes_done < 500) begin
            if ($urandom_range(0, 2) == 0)
                set_frame($urandom_range(1, 8), $urandom_range(1, 6));
            else if (fw > 16 || fh > 16)
                set_frame($urandom_range(1, 8), $urandom_range(1, 6));
            run_frame(fw, fh, 1);
        end

        wait_idle();
        $display("Ran %0d random frames after the directed rows;", frames_run);
        $display("%0d median words compared field by field.", words_checked);
        if (errors == 0 && median_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: stall on a changing pattern and check every word.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        median_word_t want;
        cycles <= cycles + 1;
        case ((cycles / 300) % 3)
            0: m_tready <= 1;
            1: m_tready <= ($urandom_range(0, 1) == 1);
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
        if (aresetn && m_tvalid && m_tready) begin
            if (median_q.size() == 0) begin
                $display("[%0t] median word with nothing expected", $realtime);
                errors++;
            end else begin
                want = median_q.pop_front();
                words_checked++;
                if (m_tdata[15:0] != want.r)  report_mismatch("red", m_tdata[15:0], want.r);
                if (m_tdata[31:16] != want.g) report_mismatch("green", m_tdata[31:16], want.g);
                if (m_tdata[47:32] != want.b) report_mismatch("blue", m_tdata[47:32], want.b);
                if (m_tdata[57:48] != want.x) report_mismatch("x", m_tdata[57:48], want.x);
                if (m_tdata[69:58] != want.y) report_mismatch("y", m_tdata[69:58], want.y);
                if (m_tlast != want.last)     report_mismatch("frame_end", m_tlast, want.last);
            end
        end
    end

    initial cycles = 0;

    // Stop a hung run.
    always @(posedge aclk) begin
        if (cycles > RunLimit) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/lrm_pkg.sv
rtl/lrm_rank.sv
rtl/luma_ranked_median_3x3_core.sv
bench/testbench.sv
